// ===== hw/rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, register codes and helpers of the patch classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

	localparam int CONF_FRAC_BITS = 10;
	localparam int Q_OUT_W        = CONF_FRAC_BITS + 1;
	localparam int QUOT_W         = CONF_FRAC_BITS;
	// 2 * margin * same is 17 bits, then the fraction shift
	localparam int DIV_NUM_W      = 17 + CONF_FRAC_BITS;
	// band2 * expected stays below 2^15
	localparam int DIV_DEN_W      = 15;
	localparam int MIN_BORDER_MARGIN = 12;
	localparam int BAND2_LOW      = 64;
	localparam int BAND2_HIGH     = 144;

	localparam logic [Q_OUT_W-1:0] Q_ONE = Q_OUT_W'(1) << CONF_FRAC_BITS;

	localparam logic [1:0] CLASS_DRIVABLE   = 2'd0;
	localparam logic [1:0] CLASS_BACKGROUND = 2'd1;
	localparam logic [1:0] CLASS_UNKNOWN    = 2'd2;
	localparam logic [1:0] CLASS_INVALID    = 2'd3;

	typedef enum logic [2:0] {
		REG_THRESHOLD     = 3'd0,
		REG_PATCH_RADIUS  = 3'd1,
		REG_FRAME_WIDTH   = 3'd2,
		REG_FRAME_HEIGHT  = 3'd3,
		REG_BORDER_EXTRA  = 3'd4,
		REG_UNKNOWN_MIN   = 3'd5,
		REG_DRIVABLE_MIN  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  threshold;
		logic [2:0]  patch_radius;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [7:0]  border_margin_extra;
		logic [10:0] unknown_conf_min;
		logic [10:0] drivable_conf_min;
	} cfg_t;

	// One finished patch, handed from the front to the back
	typedef struct packed {
		logic       invalid;
		logic       bright;
		logic       border;
		logic [7:0] run_min;
		logic [7:0] run_max;
		logic [7:0] count;
		logic [7:0] same;
		logic [7:0] margin;
	} job_t;

	// (2r+1)^2
	function automatic logic [7:0] expected_count(input logic [2:0] r);
		logic [7:0] side;
		side = {4'd0, r, 1'b1};
		return side * side;
	endfunction

	// clamp(min(max(1,t), max(1,255-t)), 64, 144)
	function automatic logic [7:0] band2(input logic [7:0] t);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] b;
		lo = (t < 8'd1) ? 8'd1 : t;
		hi = ((8'd255 - t) < 8'd1) ? 8'd1 : (8'd255 - t);
		b  = (lo < hi) ? lo : hi;
		if (b < 8'(BAND2_LOW))
			b = 8'(BAND2_LOW);
		if (b > 8'(BAND2_HIGH))
			b = 8'(BAND2_HIGH);
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcc_front.sv =====
// ----------------------------------------------------------------------------
// pcc_front
// Accepts patch pixels one per cycle while accept is high, keeps the running statistics and
// emits one job per patch on the last pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  pcc_pkg::cfg_t      cfg,
	input  logic               accept,
	input  logic [7:0]         pixel,
	input  logic               pixel_inside,
	input  logic               first_of_patch,
	input  logic               last_of_patch,
	input  logic [7:0]         center_pixel,
	input  logic signed [11:0] ctr_row,
	input  logic signed [11:0] ctr_col,
	input  logic               projection_ok,
	output logic               job_push,
	output pcc_pkg::job_t      job
);
	import pcc_pkg::*;

	logic [7:0] center_value_q;
	logic       center_bright_q;
	logic       invalid_q;
	logic       border_q;
	logic [7:0] run_min_q;
	logic [7:0] run_max_q;
	logic [7:0] count_q;
	logic [7:0] same_q;

	logic [7:0] center_n;
	logic       bright_n;
	logic       invalid_n;
	logic       border_n;
	logic [7:0] min_n;
	logic [7:0] max_n;
	logic [7:0] count_n;
	logic [7:0] same_n;

	logic              in_frame;
	logic [8:0]        margin_u;
	logic signed [13:0] row_x;
	logic signed [13:0] col_x;
	logic signed [13:0] m_x;
	logic signed [13:0] h_lim;
	logic signed [13:0] w_lim;
	logic              border_new;

	always_comb begin
		row_x    = 14'(ctr_row);
		col_x    = 14'(ctr_col);
		margin_u = 9'((cfg.border_margin_extra > 8'(MIN_BORDER_MARGIN)) ?
			cfg.border_margin_extra : 8'(MIN_BORDER_MARGIN)) + 9'(cfg.patch_radius);
		m_x      = $signed({5'd0, margin_u});
		h_lim    = $signed({2'd0, cfg.frame_height}) - 14'sd1 - m_x;
		w_lim    = $signed({2'd0, cfg.frame_width}) - 14'sd1 - m_x;
		in_frame = !ctr_row[11] && !ctr_col[11] &&
			({1'b0, ctr_row[10:0]} < cfg.frame_height) &&
			({1'b0, ctr_col[10:0]} < cfg.frame_width);
		border_new = (row_x <= m_x) || (col_x <= m_x) ||
			(row_x >= h_lim) || (col_x >= w_lim);
	end

	// restart on the first pixel, then fold in this pixel
	always_comb begin
		if (first_of_patch) begin
			center_n  = center_pixel;
			bright_n  = center_pixel > cfg.threshold;
			invalid_n = !projection_ok || !in_frame;
			border_n  = border_new;
			min_n     = 8'd255;
			max_n     = 8'd0;
			count_n   = 8'd0;
			same_n    = 8'd0;
		end else begin
			center_n  = center_value_q;
			bright_n  = center_bright_q;
			invalid_n = invalid_q;
			border_n  = border_q;
			min_n     = run_min_q;
			max_n     = run_max_q;
			count_n   = count_q;
			same_n    = same_q;
		end
		if (pixel_inside) begin
			if (pixel < min_n)
				min_n = pixel;
			if (pixel > max_n)
				max_n = pixel;
			if (count_n != 8'd255)
				count_n = count_n + 8'd1;
			if (((pixel > cfg.threshold) == bright_n) && (same_n != 8'd255))
				same_n = same_n + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_value_q  <= 8'd0;
			center_bright_q <= 1'b0;
			invalid_q       <= 1'b0;
			border_q        <= 1'b0;
			run_min_q       <= 8'd255;
			run_max_q       <= 8'd0;
			count_q         <= 8'd0;
			same_q          <= 8'd0;
		end else if (accept) begin
			center_value_q  <= center_n;
			center_bright_q <= bright_n;
			invalid_q       <= invalid_n;
			border_q        <= border_n;
			run_min_q       <= min_n;
			run_max_q       <= max_n;
			count_q         <= count_n;
			same_q          <= same_n;
		end
	end

	always_comb begin
		job_push    = accept && last_of_patch;
		job.invalid = invalid_n || (count_n == 8'd0);
		job.bright  = bright_n;
		job.border  = border_n;
		job.run_min = min_n;
		job.run_max = max_n;
		job.count   = count_n;
		job.same    = same_n;
		job.margin  = (center_n > cfg.threshold) ? (center_n - cfg.threshold)
			: (cfg.threshold - center_n);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_queue.sv =====
// ----------------------------------------------------------------------------
// pcc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcc_pkg::job_t push_job,
	input  logic          pop,
	output pcc_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);
	import pcc_pkg::*;

	job_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign head_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("job pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue fill count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && empty) |=> (cnt_q == 2'd1))
		else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_div.sv =====
// ----------------------------------------------------------------------------
// pcc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den << QUOT_W, so the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pcc_pkg::DIV_NUM_W-1:0]   num,
	input  logic [pcc_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [pcc_pkg::QUOT_W-1:0]      quot
);
	import pcc_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic [DIV_NUM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] dsh_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 take;

	assign take = (rem_q >= dsh_q);
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= DIV_NUM_W'(den) << (QUOT_W - 1);
		end else if (busy_q) begin
			if (take)
				rem_q <= rem_q - dsh_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUOT_W - 1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_back.sv =====
// ----------------------------------------------------------------------------
// pcc_back
// Takes finished jobs, works out purity and confidence on a shared divider,
// classifies and holds the result for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcc_pkg::cfg_t                 cfg,
	input  logic                          job_ready,
	input  pcc_pkg::job_t                 head_job,
	output logic                          job_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    patch_class,
	output logic [7:0]                    patch_min,
	output logic [7:0]                    patch_max,
	output logic [pcc_pkg::Q_OUT_W-1:0]   purity,
	output logic [pcc_pkg::Q_OUT_W-1:0]   confidence,
	output logic                          near_border,
	output logic                          projection_valid
);
	import pcc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_PUR  = 5'b00100,
		S_CONF = 5'b01000,
		S_FIN  = 5'b10000
	} back_state_t;

	back_state_t state_q;
	job_t        job_q;
	logic [15:0] mprod_s1;
	logic [DIV_DEN_W-1:0] dprod_s1;
	logic [Q_OUT_W-1:0]   pur_q;
	logic [Q_OUT_W-1:0]   conf_q;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [QUOT_W-1:0]    div_quot;
	logic [DIV_NUM_W-1:0] conf_num;
	logic                 conf_sat;
	logic                 out_free;
	logic [1:0]           cls;

	pcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_free = !out_valid || !out_stall;
	assign job_pop  = (state_q == S_IDLE) && job_ready;
	assign conf_num = {mprod_s1, 1'b0, CONF_FRAC_BITS'(0)};
	assign conf_sat = conf_num >= (DIV_NUM_W'(dprod_s1) << CONF_FRAC_BITS);

	always_comb begin
		div_start = 1'b0;
		div_num   = conf_num;
		div_den   = dprod_s1;
		if (state_q == S_MUL) begin
			div_start = !job_q.invalid;
			div_num   = DIV_NUM_W'({job_q.same, CONF_FRAC_BITS'(0)});
			div_den   = DIV_DEN_W'(job_q.count);
		end else if (state_q == S_PUR) begin
			div_start = div_done;
		end
	end

	always_comb begin
		if (conf_q < cfg.unknown_conf_min)
			cls = CLASS_UNKNOWN;
		else if (job_q.bright)
			cls = (conf_q >= cfg.drivable_conf_min) ? CLASS_DRIVABLE : CLASS_UNKNOWN;
		else
			cls = CLASS_BACKGROUND;
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= head_job;
		if (state_q == S_MUL) begin
			mprod_s1 <= 16'(job_q.margin) * 16'(job_q.same);
			dprod_s1 <= DIV_DEN_W'(band2(cfg.threshold)) *
				DIV_DEN_W'(expected_count(cfg.patch_radius));
		end
		if ((state_q == S_PUR) && div_done) begin
			// same == count is exactly one
			pur_q <= (job_q.same == job_q.count) ? Q_ONE : Q_OUT_W'(div_quot);
			conf_q <= conf_sat ? Q_ONE : Q_OUT_W'(0);
		end
		if ((state_q == S_CONF) && div_done && (conf_q != Q_ONE))
			conf_q <= Q_OUT_W'(div_quot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_ready)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= job_q.invalid ? S_FIN : S_PUR;
				end
				S_PUR: begin
					if (div_done)
						state_q <= S_CONF;
				end
				S_CONF: begin
					if (div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			if (job_q.invalid) begin
				patch_class      <= CLASS_INVALID;
				patch_min        <= 8'd0;
				patch_max        <= 8'd0;
				purity           <= '0;
				confidence       <= '0;
				near_border      <= 1'b0;
				projection_valid <= 1'b0;
			end else begin
				patch_class      <= cls;
				patch_min        <= job_q.run_min;
				patch_max        <= job_q.run_max;
				purity           <= pur_q;
				confidence       <= conf_q;
				near_border      <= job_q.border;
				projection_valid <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_MUL || state_q == S_PUR))
		else $error("divider started outside a division step");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == S_MUL))
		else $error("popped job not taken up");

endmodule

`default_nettype wire

// ===== hw/rtl/patch_threshold_confidence_classifier.sv =====
// ----------------------------------------------------------------------------
// patch_threshold_confidence_classifier
// Grades a square grey patch against a threshold: min, max, purity,
// confidence, border flag and class, one result per patch.
// Front takes one pixel per cycle while not stalled; stall rises only when the job queue holds two.
// Back runs two 10-step divisions on a valid patch (PUR, CONF), none on an invalid one.
// A job goes IDLE, MUL, PUR, CONF, FIN (MUL to FIN if invalid); FIN loads the result.
// Reset clears the statistics, config to defaults, queue and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module patch_threshold_confidence_classifier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         pixel,
	input  logic               pixel_inside,
	input  logic               first_of_patch,
	input  logic               last_of_patch,
	input  logic [7:0]         center_pixel,
	input  logic signed [11:0] ctr_row,
	input  logic signed [11:0] ctr_col,
	input  logic               projection_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         patch_class,
	output logic [7:0]         patch_min,
	output logic [7:0]         patch_max,
	output logic [10:0]        purity,
	output logic [10:0]        confidence,
	output logic               near_border,
	output logic               projection_valid
);
	import pcc_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic job_push;
	logic job_pop;
	logic q_full;
	logic q_empty;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold           <= 8'd128;
			cfg_q.patch_radius        <= 3'd1;
			cfg_q.frame_width         <= 12'd320;
			cfg_q.frame_height        <= 12'd240;
			cfg_q.border_margin_extra <= 8'd0;
			cfg_q.unknown_conf_min    <= 11'd256;
			cfg_q.drivable_conf_min   <= 11'd512;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:    cfg_q.threshold           <= cfg_data[7:0];
				REG_PATCH_RADIUS: cfg_q.patch_radius        <= cfg_data[2:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width         <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height        <= cfg_data;
				REG_BORDER_EXTRA: cfg_q.border_margin_extra <= cfg_data[7:0];
				REG_UNKNOWN_MIN:  cfg_q.unknown_conf_min    <= cfg_data[10:0];
				REG_DRIVABLE_MIN: cfg_q.drivable_conf_min   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	pcc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.accept         (accept),
		.pixel          (pixel),
		.pixel_inside   (pixel_inside),
		.first_of_patch (first_of_patch),
		.last_of_patch  (last_of_patch),
		.center_pixel   (center_pixel),
		.ctr_row        (ctr_row),
		.ctr_col        (ctr_col),
		.projection_ok  (projection_ok),
		.job_push       (job_push),
		.job            (push_job)
	);

	pcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	pcc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.job_ready        (!q_empty),
		.head_job         (head_job),
		.job_pop          (job_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.patch_class      (patch_class),
		.patch_min        (patch_min),
		.patch_max        (patch_max),
		.purity           (purity),
		.confidence       (confidence),
		.near_border      (near_border),
		.projection_valid (projection_valid)
	);

endmodule

`default_nettype wire

// ===== tb/patch_grade_checker.sv =====
// ----------------------------------------------------------------------------
// patch_grade_checker
// Watches the register, pixel and grade channels of the patch classifier.
// Keeps its own copy of the registers and the patch statistics, predicts one
// grade per closed patch and compares each accepted grade field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module patch_grade_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         pixel,
	input  logic               pixel_inside,
	input  logic               first_of_patch,
	input  logic               last_of_patch,
	input  logic [7:0]         center_pixel,
	input  logic signed [11:0] ctr_row,
	input  logic signed [11:0] ctr_col,
	input  logic               projection_ok,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         patch_class,
	input  logic [7:0]         patch_min,
	input  logic [7:0]         patch_max,
	input  logic [10:0]        purity,
	input  logic [10:0]        confidence,
	input  logic               near_border,
	input  logic               projection_valid,
	output int                 failures,
	output int                 pending_results
);
	import pcc_pkg::*;

	typedef struct packed {
		logic [1:0]  cls;
		logic [7:0]  pmin;
		logic [7:0]  pmax;
		logic [10:0] pur;
		logic [10:0] conf;
		logic        border;
		logic        valid;
	} grade_t;

	// register copy
	logic [7:0]  thr_q;
	logic [2:0]  radius_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [7:0]  border_extra_q;
	logic [10:0] unknown_min_q;
	logic [10:0] drivable_min_q;

	// patch statistics
	logic [7:0]  center_q;
	logic        bright_q;
	logic        invalid_q;
	logic        border_q;
	logic [7:0]  darkest_q;
	logic [7:0]  brightest_q;
	int          count_q;
	int          same_q;

	grade_t expected_grades[$];
	int     errors = 0;

	function automatic grade_t grade_patch();
		grade_t g;
		int     t;
		int     r;
		int     c;
		int     lo;
		int     hi;
		int     band;
		int     margin;
		longint cells;
		longint pur;
		longint conf;
		g = '0;
		g.cls = CLASS_INVALID;
		if (invalid_q || count_q == 0)
			return g;
		t = thr_q;
		r = radius_q;
		c = center_q;
		cells = (2 * r + 1) * (2 * r + 1);
		lo = (t < 1) ? 1 : t;
		hi = ((255 - t) < 1) ? 1 : 255 - t;
		band = (lo < hi) ? lo : hi;
		if (band < BAND2_LOW)
			band = BAND2_LOW;
		if (band > BAND2_HIGH)
			band = BAND2_HIGH;
		margin = (c > t) ? c - t : t - c;
		pur = (longint'(same_q) << CONF_FRAC_BITS) / count_q;
		conf = (longint'(2 * margin * same_q) << CONF_FRAC_BITS) / (band * cells);
		if (conf > (longint'(1) << CONF_FRAC_BITS))
			conf = longint'(1) << CONF_FRAC_BITS;
		if (pur > (longint'(1) << CONF_FRAC_BITS))
			pur = longint'(1) << CONF_FRAC_BITS;
		if (conf < longint'(unknown_min_q))
			g.cls = CLASS_UNKNOWN;
		else if (bright_q)
			g.cls = (conf >= longint'(drivable_min_q)) ? CLASS_DRIVABLE : CLASS_UNKNOWN;
		else
			g.cls = CLASS_BACKGROUND;
		g.pmin = darkest_q;
		g.pmax = brightest_q;
		g.pur = 11'(pur);
		g.conf = 11'(conf);
		g.border = border_q;
		g.valid = 1'b1;
		return g;
	endfunction

	task automatic absorb_pixel();
		int row;
		int col;
		int h;
		int w;
		int m;
		if (first_of_patch) begin
			row = ctr_row;
			col = ctr_col;
			h = height_q;
			w = width_q;
			m = ((int'(border_extra_q) > MIN_BORDER_MARGIN) ? int'(border_extra_q)
				: MIN_BORDER_MARGIN) + int'(radius_q);
			center_q = center_pixel;
			bright_q = center_pixel > thr_q;
			invalid_q = !projection_ok || row < 0 || col < 0 || row >= h || col >= w;
			border_q = row <= m || col <= m || row >= h - 1 - m || col >= w - 1 - m;
			darkest_q = 8'hFF;
			brightest_q = 8'h00;
			count_q = 0;
			same_q = 0;
		end
		if (pixel_inside) begin
			if (pixel < darkest_q)
				darkest_q = pixel;
			if (pixel > brightest_q)
				brightest_q = pixel;
			if (count_q < 255)
				count_q++;
			if ((pixel > thr_q) == bright_q && same_q < 255)
				same_q++;
		end
		if (last_of_patch)
			expected_grades.insert(expected_grades.size(), grade_patch());
	endtask

	task automatic take_register();
		case (cfg_reg_t'(cfg_index))
			REG_THRESHOLD:    thr_q = cfg_data[7:0];
			REG_PATCH_RADIUS: radius_q = cfg_data[2:0];
			REG_FRAME_WIDTH:  width_q = cfg_data;
			REG_FRAME_HEIGHT: height_q = cfg_data;
			REG_BORDER_EXTRA: border_extra_q = cfg_data[7:0];
			REG_UNKNOWN_MIN:  unknown_min_q = cfg_data[10:0];
			REG_DRIVABLE_MIN: drivable_min_q = cfg_data[10:0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
		end
	endtask

	task automatic match_grade();
		grade_t want;
		if (expected_grades.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: grade with no patch pending: class %0d min %0d max %0d",
					$realtime, patch_class, patch_min, patch_max);
		end else begin
			want = expected_grades.pop_front();
			check_field("patch_class", want.cls, patch_class);
			check_field("patch_min", want.pmin, patch_min);
			check_field("patch_max", want.pmax, patch_max);
			check_field("purity", want.pur, purity);
			check_field("confidence", want.conf, confidence);
			check_field("near_border", want.border, near_border);
			check_field("projection_valid", want.valid, projection_valid);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q = 8'd128;
			radius_q = 3'd1;
			width_q = 12'd320;
			height_q = 12'd240;
			border_extra_q = 8'd0;
			unknown_min_q = 11'd256;
			drivable_min_q = 11'd512;
			center_q = 8'd0;
			bright_q = 1'b0;
			invalid_q = 1'b0;
			border_q = 1'b0;
			darkest_q = 8'hFF;
			brightest_q = 8'h00;
			count_q = 0;
			same_q = 0;
			expected_grades.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				take_register();
			// retire before adding: a grade never belongs to this cycle's request
			if (out_valid && !out_stall)
				match_grade();
			if (in_valid && !in_stall)
				absorb_pixel();
		end
		failures <= errors;
		pending_results <= expected_grades.size();
	end

endmodule

// ===== tb/tb_patch_threshold_confidence_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_patch_threshold_confidence_classifier
// Drives patches of grey pixels into the classifier under several register
// settings, with random gaps and stalls and one long output hold-off.
// A checker beside the block predicts and compares every grade.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_patch_threshold_confidence_classifier;
	import pcc_pkg::*;

	typedef struct packed {
		logic [7:0]  px;
		logic        in_img;
		logic        first;
		logic        last;
		logic [7:0]  cp;
		logic [11:0] row;
		logic [11:0] col;
		logic        ok;
	} patch_item_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         pixel = '0;
	logic               pixel_inside = 1'b0;
	logic               first_of_patch = 1'b0;
	logic               last_of_patch = 1'b0;
	logic [7:0]         center_pixel = '0;
	logic signed [11:0] ctr_row = '0;
	logic signed [11:0] ctr_col = '0;
	logic               projection_ok = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         patch_class;
	logic [7:0]         patch_min;
	logic [7:0]         patch_max;
	logic [10:0]        purity;
	logic [10:0]        confidence;
	logic               near_border;
	logic               projection_valid;

	int failures;
	int pending_results;
	int idle_pct = 14;
	bit squeeze = 1'b0;
	int items_sent = 0;

	// register values as last written, for aiming centers and pixels
	int cur_thr = 128;
	int cur_r = 1;
	int cur_w = 320;
	int cur_h = 240;
	int cur_m = 13;

	patch_threshold_confidence_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel(pixel), .pixel_inside(pixel_inside),
		.first_of_patch(first_of_patch), .last_of_patch(last_of_patch),
		.center_pixel(center_pixel), .ctr_row(ctr_row),
		.ctr_col(ctr_col), .projection_ok(projection_ok),
		.out_valid(out_valid), .out_stall(out_stall),
		.patch_class(patch_class), .patch_min(patch_min), .patch_max(patch_max),
		.purity(purity), .confidence(confidence),
		.near_border(near_border), .projection_valid(projection_valid)
	);

	patch_grade_checker grade_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel(pixel), .pixel_inside(pixel_inside),
		.first_of_patch(first_of_patch), .last_of_patch(last_of_patch),
		.center_pixel(center_pixel), .ctr_row(ctr_row),
		.ctr_col(ctr_col), .projection_ok(projection_ok),
		.out_valid(out_valid), .out_stall(out_stall),
		.patch_class(patch_class), .patch_min(patch_min), .patch_max(patch_max),
		.purity(purity), .confidence(confidence),
		.near_border(near_border), .projection_valid(projection_valid),
		.failures(failures), .pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("patch_threshold_confidence_classifier test failed");
		$finish;
	end

	// grade receiver
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && !held) begin
				held = 1'b1;
				// hold off until the job queue fills and the input stalls
				repeat (400) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	function automatic patch_item_t mk(input logic [7:0] px, input logic in_img,
			input logic first, input logic last, input logic [7:0] cp,
			input logic [11:0] row, input logic [11:0] col, input logic ok);
		patch_item_t it;
		it.px = px;
		it.in_img = in_img;
		it.first = first;
		it.last = last;
		it.cp = cp;
		it.row = row;
		it.col = col;
		it.ok = ok;
		return it;
	endfunction

	task automatic offer(input patch_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= it.px;
		pixel_inside <= it.in_img;
		first_of_patch <= it.first;
		last_of_patch <= it.last;
		center_pixel <= it.cp;
		ctr_row <= it.row;
		ctr_col <= it.col;
		projection_ok <= it.ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// drop valid and let every pending grade and the back end finish
	task automatic quiesce(input int tail);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 12'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_setting(input int thr, input int r, input int w, input int h,
			input int extra, input int unk, input int drv);
		quiesce(40);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_PATCH_RADIUS, r);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BORDER_EXTRA, extra);
		write_reg(REG_UNKNOWN_MIN, unk);
		write_reg(REG_DRIVABLE_MIN, drv);
		cfg_valid <= 1'b0;
		@(posedge clk);
		cur_thr = thr;
		cur_r = r;
		cur_w = w;
		cur_h = h;
		cur_m = ((extra > MIN_BORDER_MARGIN) ? extra : MIN_BORDER_MARGIN) + r;
	endtask

	// styles: any value, bright side, dark side, close to the threshold
	function automatic logic [7:0] shade(input int style);
		int v;
		case (style)
			0: v = $urandom_range(0, 255);
			1: v = (cur_thr < 255) ? $urandom_range(cur_thr + 1, 255) : 255;
			2: v = $urandom_range(0, cur_thr);
			default: v = cur_thr + int'($urandom_range(0, 6)) - 3;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic logic [11:0] pick_coord(input int size);
		int sel;
		int lim;
		int v;
		sel = $urandom_range(0, 99);
		lim = (size > 2048) ? 2048 : size;
		if (sel < 12 || lim < 1)
			return 12'($urandom);
		if (sel < 32)
			v = $urandom_range(0, cur_m + 2);
		else if (sel < 50)
			v = size - 1 - int'($urandom_range(0, cur_m + 2));
		else
			v = $urandom_range(0, lim - 1);
		if (v < 0 || v > 2047)
			v = $urandom_range(0, lim - 1);
		return 12'(v);
	endfunction

	task automatic send_patch(input int len, input bit with_first, input bit with_last,
			input bit dense);
		int          style;
		bit          none_in;
		bit          in_img;
		logic [7:0]  cp;
		logic [11:0] row;
		logic [11:0] col;
		logic        ok;
		style = $urandom_range(0, 3);
		cp = ($urandom_range(0, 9) < 7) ? shade(style) : shade($urandom_range(0, 3));
		row = pick_coord(cur_h);
		col = pick_coord(cur_w);
		ok = ($urandom_range(0, 15) != 0);
		none_in = !dense && ($urandom_range(0, 19) == 0);
		for (int k = 0; k < len; k++) begin
			in_img = dense || (!none_in && $urandom_range(0, 9) != 0);
			if (k == 0)
				offer(mk(($urandom_range(0, 99) < 85) ? shade(style) : shade(0), in_img,
					with_first, with_last && len == 1, cp, row, col, ok));
			else
				offer(mk(($urandom_range(0, 99) < 85) ? shade(style) : shade(0), in_img,
					1'b0, with_last && k == len - 1, 8'($urandom), 12'($urandom),
					12'($urandom), 1'($urandom)));
		end
	endtask

	task automatic random_patch();
		int sel;
		int len;
		sel = $urandom_range(0, 99);
		if (cur_r >= 4 || $urandom_range(0, 3) == 0)
			len = $urandom_range(1, 12);
		else
			len = (2 * cur_r + 1) * (2 * cur_r + 1);
		if (sel < 84)
			send_patch(len, 1'b1, 1'b1, 1'b0);
		else if (sel < 90)
			send_patch(1, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
		else if (sel < 95)
			send_patch(len, 1'b0, 1'b1, 1'b0);
		else
			send_patch(len, 1'b1, 1'b0, 1'b0);
	endtask

	function automatic int pick_frame();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			return 0;
		if (sel < 20)
			return $urandom_range(1, 4095);
		return $urandom_range(1, 640);
	endfunction

	function automatic int pick_conf_limit();
		return ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(0, 1024);
	endfunction

	initial begin
		int start;
		int budget;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pixels before any patch add to the reset statistics
		offer(mk(8'd200, 1'b1, 1'b0, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
		offer(mk(8'd50, 1'b1, 1'b0, 1'b1, 8'd0, 12'd0, 12'd0, 1'b0));
		// one-pixel patches at the grey extremes
		offer(mk(8'd0, 1'b1, 1'b1, 1'b1, 8'd255, 12'd100, 12'd100, 1'b1));
		offer(mk(8'd255, 1'b1, 1'b1, 1'b1, 8'd0, 12'd120, 12'd160, 1'b1));
		// failed projection
		offer(mk(8'd255, 1'b1, 1'b1, 1'b0, 8'd200, 12'd50, 12'd50, 1'b0));
		offer(mk(8'd10, 1'b1, 1'b0, 1'b1, 8'hAA, 12'h555, 12'hAAA, 1'b1));
		// centers outside the frame
		offer(mk(8'd90, 1'b1, 1'b1, 1'b1, 8'd200, 12'hFFF, 12'd10, 1'b1));
		offer(mk(8'd90, 1'b1, 1'b1, 1'b1, 8'd200, 12'h800, 12'h7FF, 1'b1));
		offer(mk(8'd90, 1'b1, 1'b1, 1'b1, 8'd200, 12'd10, 12'd320, 1'b1));
		// last row and column still inside
		offer(mk(8'd140, 1'b1, 1'b1, 1'b1, 8'd200, 12'd239, 12'd319, 1'b1));
		offer(mk(8'd140, 1'b1, 1'b1, 1'b1, 8'd200, 12'd0, 12'd0, 1'b1));
		// no pixel inside the image
		offer(mk(8'd77, 1'b0, 1'b1, 1'b0, 8'd200, 12'd100, 12'd100, 1'b1));
		offer(mk(8'd77, 1'b0, 1'b0, 1'b1, 8'd0, 12'd0, 12'd0, 1'b0));
		// center on the threshold gives zero margin
		offer(mk(8'd128, 1'b1, 1'b1, 1'b1, 8'd128, 12'd100, 12'd100, 1'b1));
		// full bright patch, then a stray last request after it
		for (int k = 0; k < 9; k++)
			offer(mk(8'd255, 1'b1, k == 0, k == 8, 8'd255, 12'd100, 12'd150, 1'b1));
		offer(mk(8'd30, 1'b1, 1'b0, 1'b1, 8'd0, 12'd0, 12'd0, 1'b0));

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: apply_setting(0, 0, 1, 1, 0, 0, 0);
				1: apply_setting(255, 7, 4095, 4095, 255, 1024, 1024);
				2: apply_setting(128, 0, 320, 240, 12, 256, 512);
				default: apply_setting($urandom_range(0, 255), $urandom_range(0, 2),
					pick_frame(), pick_frame(),
					$urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255),
					pick_conf_limit(), pick_conf_limit());
			endcase
			idle_pct = (phase == 3) ? 0 : 14;
			if (phase == 2)
				squeeze = 1'b1;
			// largest patch, long enough to saturate the pixel counts
			if (phase == 1)
				send_patch(262, 1'b1, 1'b1, 1'b1);
			budget = (phase == 3) ? 120 : 40;
			start = items_sent;
			while (items_sent - start < budget)
				random_patch();
		end

		quiesce(60);
		if (failures == 0 && pending_results == 0)
			$display("patch_threshold_confidence_classifier test passed");
		else
			$display("patch_threshold_confidence_classifier test failed");
		$finish;
	end

endmodule

// ===== patch_threshold_confidence_classifier.f =====
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_front.sv
hw/rtl/pcc_queue.sv
hw/rtl/pcc_div.sv
hw/rtl/pcc_back.sv
hw/rtl/patch_threshold_confidence_classifier.sv
tb/patch_grade_checker.sv
tb/tb_patch_threshold_confidence_classifier.sv
